// ===== design/srl_pkg.sv =====
// Package for the symmetry representative lookup block.
// Holds transaction types, command codes, sequencer states and table sizes.
// No dependencies.
package srl_pkg;

  localparam int STATE_BITS     = 32;
  localparam int MAX_SUBLAT     = 4;
  localparam int CHUNK_BITS     = 8;
  localparam int MAX_SYMMETRIES = 32;

  localparam int SUB_W  = $clog2(MAX_SUBLAT);
  localparam int SYM_W  = $clog2(MAX_SYMMETRIES);
  localparam int REP_AW = SUB_W + CHUNK_BITS;
  localparam int ACT_AW = SUB_W + SYM_W + CHUNK_BITS;

  localparam logic [1:0] CFG_SITES   = 2'd0;
  localparam logic [1:0] CFG_SUBLATS = 2'd1;

  typedef enum logic [2:0] {
    CMD_WR_REP  = 3'd0,
    CMD_WR_ACT  = 3'd1,
    CMD_WR_MASK = 3'd2,
    CMD_APPLY   = 3'd3,
    CMD_FIND    = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  sublattice_index;
    logic [4:0]  symmetry_index;
    logic [7:0]  chunk_value;
    logic [31:0] write_data;
    logic [31:0] state_in;
  } in_t;

  typedef struct packed {
    logic [31:0] result_state;
    logic [4:0]  first_symmetry;
    logic [7:0]  symmetry_count;
    logic [31:0] symmetry_mask;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REP_RD,
    ST_REP_WAIT,
    ST_SUB_NEXT,
    ST_MASK_WAIT,
    ST_SYM_SCAN,
    ST_IMG_RD,
    ST_IMG_WAIT,
    ST_CAND,
    ST_DONE
  } state_t;

endpackage

// ===== design/srl_action_img.sv =====
// Image accumulator: ORs one symmetry's chunk images from the action table.
// Holds the action-table memory; reads one chunk per cycle while rd_en is high. Uses srl_pkg.
module srl_action_img import srl_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ACT_AW-1:0] wr_addr,
  input  logic [31:0]       wr_data,
  input  logic              rd_en,
  input  logic [ACT_AW-1:0] rd_addr,
  input  logic              acc_clr,
  input  logic              acc_en,
  output logic [31:0]       img
);

  logic [31:0] act_mem [2**ACT_AW];
  logic [31:0] rd_q_r;
  logic [31:0] img_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      act_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= act_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_clr) begin
      img_r <= '0;
    end else if (acc_en) begin
      img_r <= img_r | rd_q_r;
    end
  end

  assign img = img_r;

endmodule

// ===== design/symmetry_representative_lookup.sv =====
// Top level of the symmetry representative lookup block.
// Holds the command sequencer and rep/mask tables; uses srl_pkg and srl_action_img.
//
// Usage: one input transaction per command on in_valid/in_stall, one result
// transaction per command on out_valid/out_stall. Write commands load the
// chunk representative, symmetry mask or action tables; apply returns the OR
// of chunk images under one symmetry; find returns the smallest image over
// all symmetries listed by tied chunks, its first symmetry, the hit count
// and a symmetry mask. The cfg_ port sets chunk width and chunk count; write
// it only while idle.
// Steps: apply reads and ORs the image of each used chunk; find first reads
// each chunk's representative, then checks each chunk for a tie, scans the
// mask of each tied chunk and images each listed symmetry. One action-table
// read port feeds one OR accumulator; one command is in work at a time.
// in_stall stays high from acceptance until the result is taken. A stalled
// result holds. Reset clears the sequencer and out_valid and sets chunk width
// 8 and chunk count 4; tables stay undefined until written.
module symmetry_representative_lookup import srl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  state_t state_r, state_nxt;
  logic [3:0] sites_r;
  logic [2:0] sublats_r;
  in_t  req_r;
  out_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [CHUNK_BITS-1:0] rep_mem  [2**REP_AW];
  logic [31:0]           mask_mem [2**REP_AW];
  logic [CHUNK_BITS-1:0] rep_q_r;
  logic [31:0]           mask_q_r;

  logic [SUB_W:0]  sub_r, sub_nxt;
  logic [SUB_W:0]  tie_r, tie_nxt;
  logic [SYM_W:0]  sym_r, sym_nxt;
  logic [CHUNK_BITS-1:0] minrep_r, minrep_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic        have_r, have_nxt;

  logic [3:0] w;
  logic [2:0] n;
  logic [CHUNK_BITS-1:0] chunk;
  logic [5:0] shift;
  logic [31:0] shifted;
  logic [SUB_W-1:0] sub_idx;
  logic rep_rd, mask_rd, act_rd, acc_clr, acc_en;
  logic [SYM_W-1:0] act_sym;
  logic [31:0] img;
  logic wr_act;

  always_comb begin
    w = (sites_r == 4'd0) ? 4'd1 : (sites_r > 4'(CHUNK_BITS)) ? 4'(CHUNK_BITS) : sites_r;
    n = (sublats_r == 3'd0) ? 3'd1 :
        (sublats_r > 3'(MAX_SUBLAT)) ? 3'(MAX_SUBLAT) : sublats_r;
    sub_idx = sub_r[SUB_W-1:0];
    shift = 6'(sub_idx) * 6'(w);
    shifted = req_r.state_in >> shift;
    chunk = (shift >= 6'(STATE_BITS)) ? '0 :
            CHUNK_BITS'(shifted & ((32'd1 << w) - 32'd1));
  end

  assign wr_act = in_valid && !in_stall && in_data.command == CMD_WR_ACT;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall && in_data.command == CMD_WR_REP) begin
      rep_mem[{in_data.sublattice_index, in_data.chunk_value}] <= in_data.write_data[7:0];
    end
    if (in_valid && !in_stall && in_data.command == CMD_WR_MASK) begin
      mask_mem[{in_data.sublattice_index, in_data.chunk_value}] <= in_data.write_data;
    end
    if (rep_rd) begin
      rep_q_r <= rep_mem[{sub_idx, chunk}];
    end
    if (mask_rd) begin
      mask_q_r <= mask_mem[{sub_idx, chunk}];
    end
  end

  srl_action_img u_img (
    .clk     (clk),
    .wr_en   (wr_act),
    .wr_addr ({in_data.sublattice_index, in_data.symmetry_index, in_data.chunk_value}),
    .wr_data (in_data.write_data),
    .rd_en   (act_rd),
    .rd_addr ({sub_idx, act_sym, chunk}),
    .acc_clr (acc_clr),
    .acc_en  (acc_en),
    .img     (img)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sites_r   <= 4'd8;
      sublats_r <= 3'd4;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SITES) sites_r <= cfg_data;
      if (cfg_index == CFG_SUBLATS) sublats_r <= cfg_data[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_valid && !in_stall) req_r <= in_data;
    res_r    <= res_nxt;
    sub_r    <= sub_nxt;
    tie_r    <= tie_nxt;
    sym_r    <= sym_nxt;
    minrep_r <= minrep_nxt;
    mask_r   <= mask_nxt;
    have_r   <= have_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt    = res_r;
    sub_nxt    = sub_r;
    tie_nxt    = tie_r;
    sym_nxt    = sym_r;
    minrep_nxt = minrep_r;
    mask_nxt   = mask_r;
    have_nxt   = have_r;
    rep_rd = 1'b0;
    mask_rd = 1'b0;
    act_rd = 1'b0;
    acc_clr = 1'b0;
    acc_en = 1'b0;
    act_sym = (req_r.command == CMD_APPLY) ? req_r.symmetry_index : sym_r[SYM_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          res_nxt = '0;
          sub_nxt = '0;
          have_nxt = 1'b0;
          if (in_data.command == CMD_APPLY) begin
            state_nxt = ST_IMG_RD;
          end else if (in_data.command == CMD_FIND) begin
            state_nxt = ST_REP_RD;
            res_nxt.result_state = '1;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_REP_RD: begin
        rep_rd = 1'b1;
        state_nxt = ST_REP_WAIT;
      end
      ST_REP_WAIT: begin
        if (sub_r == '0 || rep_q_r < minrep_r) minrep_nxt = rep_q_r;
        if (sub_r + 1'b1 >= (SUB_W+1)'(n)) begin
          sub_nxt = '0;
          tie_nxt = '0;
          state_nxt = ST_SUB_NEXT;
        end else begin
          sub_nxt = sub_r + 1'b1;
          state_nxt = ST_REP_RD;
        end
      end
      ST_SUB_NEXT: begin
        if (tie_r >= (SUB_W+1)'(n)) begin
          state_nxt = ST_DONE;
        end else begin
          sub_nxt = tie_r;
          rep_rd = 1'b1;
          mask_rd = 1'b1;
          state_nxt = ST_MASK_WAIT;
        end
      end
      ST_MASK_WAIT: begin
        if (rep_q_r == minrep_r) begin
          mask_nxt = mask_q_r;
          sym_nxt = '0;
          state_nxt = ST_SYM_SCAN;
        end else begin
          tie_nxt = tie_r + 1'b1;
          sub_nxt = tie_r + 1'b1;
          state_nxt = ST_SUB_NEXT;
        end
      end
      ST_SYM_SCAN: begin
        if (sym_r >= (SYM_W+1)'(MAX_SYMMETRIES)) begin
          tie_nxt = tie_r + 1'b1;
          sub_nxt = tie_r + 1'b1;
          state_nxt = ST_SUB_NEXT;
        end else if (mask_r[sym_r[SYM_W-1:0]]) begin
          sub_nxt = '0;
          acc_clr = 1'b1;
          state_nxt = ST_IMG_RD;
        end else begin
          sym_nxt = sym_r + 1'b1;
        end
      end
      ST_IMG_RD: begin
        act_rd = 1'b1;
        if (sub_r == '0) acc_clr = 1'b1;
        state_nxt = ST_IMG_WAIT;
      end
      ST_IMG_WAIT: begin
        acc_en = 1'b1;
        if (sub_r + 1'b1 >= (SUB_W+1)'(n)) begin
          state_nxt = ST_CAND;
        end else begin
          sub_nxt = sub_r + 1'b1;
          state_nxt = ST_IMG_RD;
        end
      end
      ST_CAND: begin
        if (req_r.command == CMD_APPLY) begin
          res_nxt.result_state = img;
          state_nxt = ST_DONE;
        end else begin
          if (!have_r || img < res_r.result_state) begin
            have_nxt = 1'b1;
            res_nxt.result_state = img;
            res_nxt.first_symmetry = sym_r[SYM_W-1:0];
            res_nxt.symmetry_count = 8'd1;
            res_nxt.symmetry_mask = 32'd1 << sym_r[SYM_W-1:0];
          end else if (img == res_r.result_state) begin
            if (res_r.symmetry_count != 8'hFF)
              res_nxt.symmetry_count = res_r.symmetry_count + 8'd1;
            res_nxt.symmetry_mask = res_r.symmetry_mask | (32'd1 << sym_r[SYM_W-1:0]);
          end
          sym_nxt = sym_r + 1'b1;
          state_nxt = ST_SYM_SCAN;
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result dropped under stall");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> out_valid)
    else $error("missing result");
  a_count_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.symmetry_count == 8'd0) |-> (out_data.symmetry_mask == '0))
    else $error("mask without hits");

endmodule

// ===== dv/symmetry_representative_lookup_tb.sv =====
// Self-checking testbench for the symmetry representative lookup block.
// Loads the table entries for a few chunk values, then runs directed and random commands
// under several configs and idle patterns against an in-bench predictor; uses srl_pkg.
module symmetry_representative_lookup_tb;
  import srl_pkg::*;

  localparam int LIMIT = 10000000;
  localparam int FILL_CHUNKS = 4;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;

  symmetry_representative_lookup i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bit [7:0]  rep_tab [MAX_SUBLAT][1 << CHUNK_BITS];
  bit [31:0] sym_mask_tab [MAX_SUBLAT][1 << CHUNK_BITS];
  bit [31:0] image_tab [MAX_SUBLAT][MAX_SYMMETRIES][1 << CHUNK_BITS];
  bit [3:0]  sites_reg;
  bit [2:0]  sublats_reg;

  in_t  pending_cmds[$];
  out_t expected_results[$];
  int   snd_idle_pct;
  int   rcv_idle_pct;
  int   mismatches = 0;
  int   cycles = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic bit [31:0] symmetry_image(bit [7:0] chunks[MAX_SUBLAT], int n, int sym);
    bit [31:0] r;
    r = '0;
    for (int s = 0; s < n; s++) r |= image_tab[s][sym][chunks[s]];
    return r;
  endfunction

  function automatic out_t lookup_result(in_t t);
    out_t      o;
    int        w;
    int        n;
    int        sh;
    bit [7:0]  chunks[MAX_SUBLAT];
    bit [7:0]  reps[MAX_SUBLAT];
    bit [7:0]  minrep;
    bit [31:0] m;
    bit [31:0] cand;
    bit        found;
    o = '0;
    w = (sites_reg < 1) ? 1 : (sites_reg > CHUNK_BITS) ? CHUNK_BITS : sites_reg;
    n = (sublats_reg < 1) ? 1 : (sublats_reg > MAX_SUBLAT) ? MAX_SUBLAT : sublats_reg;
    case (t.command)
      CMD_WR_REP: rep_tab[t.sublattice_index][t.chunk_value] = t.write_data[7:0];
      CMD_WR_ACT:
        image_tab[t.sublattice_index][t.symmetry_index][t.chunk_value] = t.write_data;
      CMD_WR_MASK: sym_mask_tab[t.sublattice_index][t.chunk_value] = t.write_data;
      CMD_APPLY, CMD_FIND: begin
        for (int s = 0; s < MAX_SUBLAT; s++) begin
          sh = s * w;
          chunks[s] = (sh >= STATE_BITS) ? 8'd0 : 8'((t.state_in >> sh) & ((1 << w) - 1));
          reps[s] = rep_tab[s][chunks[s]];
        end
        if (t.command == CMD_APPLY) begin
          o.result_state = symmetry_image(chunks, n, t.symmetry_index);
        end else begin
          minrep = reps[0];
          for (int s = 1; s < n; s++) if (reps[s] < minrep) minrep = reps[s];
          o.result_state = '1;
          found = 1'b0;
          for (int s = 0; s < n; s++) begin
            if (reps[s] != minrep) continue;
            m = sym_mask_tab[s][chunks[s]];
            for (int j = 0; j < MAX_SYMMETRIES; j++) begin
              if (!m[j]) continue;
              cand = symmetry_image(chunks, n, j);
              if (!found || cand < o.result_state) begin
                found = 1'b1;
                o.result_state = cand;
                o.first_symmetry = 5'(j);
                o.symmetry_count = 8'd1;
                o.symmetry_mask = 32'd1 << j;
              end else if (cand == o.result_state) begin
                if (o.symmetry_count < 8'd255) o.symmetry_count++;
                o.symmetry_mask[j] = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.insert(expected_results.size(), lookup_result(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_cmds.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", out_data);
      end else begin
        out_t exp_r;
        exp_r = expected_results.pop_front();
        if (out_data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %0d %0d %h, got %h %0d %0d %h",
                     exp_r.result_state, exp_r.first_symmetry, exp_r.symmetry_count,
                     exp_r.symmetry_mask, out_data.result_state, out_data.first_symmetry,
                     out_data.symmetry_count, out_data.symmetry_mask);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("symmetry_representative_lookup_tb: FAIL");
      $finish;
    end
  end

  function automatic in_t mk(logic [2:0] cmd, int sub, int sym, int cv,
                             logic [31:0] wd, logic [31:0] st);
    in_t t;
    t.command = cmd;
    t.sublattice_index = 2'(sub);
    t.symmetry_index = 5'(sym);
    t.chunk_value = 8'(cv);
    t.write_data = wd;
    t.state_in = st;
    return t;
  endfunction

  task automatic add_cmd(in_t t);
    pending_cmds.insert(pending_cmds.size(), t);
  endtask

  function automatic logic [31:0] sparse_mask();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] rep_word();
    logic [31:0] d;
    d = $urandom;
    d[7:0] = $urandom_range(0, 7);
    return d;
  endfunction

  function automatic logic [31:0] image_word();
    return ($urandom_range(0, 63) == 0) ? '1 : $urandom;
  endfunction

  // keep every used chunk among the loaded chunk values; mode 1 all zero, mode 2 all top
  function automatic logic [31:0] loaded_state(int mode);
    int          w;
    int          n;
    int          sh;
    int          c;
    logic [31:0] st;
    logic [31:0] cm;
    w = (sites_reg < 1) ? 1 : (sites_reg > CHUNK_BITS) ? CHUNK_BITS : sites_reg;
    n = (sublats_reg < 1) ? 1 : (sublats_reg > MAX_SUBLAT) ? MAX_SUBLAT : sublats_reg;
    st = $urandom;
    cm = (32'd1 << w) - 32'd1;
    for (int s = 0; s < n; s++) begin
      sh = s * w;
      c = (mode == 1) ? 0 : (mode == 2) ? FILL_CHUNKS - 1 : $urandom_range(0, FILL_CHUNKS - 1);
      st = (st & ~(cm << sh)) | ((32'(c) & cm) << sh);
    end
    return st;
  endfunction

  function automatic in_t random_cmd();
    int          r;
    logic [31:0] st;
    r = $urandom_range(0, 99);
    st = loaded_state(($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : 0);
    if (r < 40) return mk(CMD_FIND, $urandom, $urandom, $urandom, $urandom, st);
    if (r < 70) return mk(CMD_APPLY, $urandom, $urandom, $urandom, $urandom, st);
    if (r < 76) return mk(CMD_WR_REP, $urandom, $urandom, $urandom, rep_word(), st);
    if (r < 82) return mk(CMD_WR_MASK, $urandom, $urandom, $urandom, sparse_mask(), st);
    if (r < 94) return mk(CMD_WR_ACT, $urandom, $urandom, $urandom, image_word(), st);
    return mk(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom, st);
  endfunction

  task automatic drain();
    while (pending_cmds.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [3:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_SITES) sites_reg = val;
    else sublats_reg = 3'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  int cfg_sites[6]   = '{8, 1, 15, 0, 3, 5};
  int cfg_sublats[6] = '{4, 1, 7, 0, 3, 2};
  int snd_pct[6]     = '{0, 81, 0, 10, 0, 81};
  int rcv_pct[6]     = '{0, 0, 81, 10, 81, 0};

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    sites_reg = 4'd8;
    sublats_reg = 3'd4;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // load every entry for the low chunk values; states only use those chunks
    for (int s = 0; s < MAX_SUBLAT; s++)
      for (int c = 0; c < FILL_CHUNKS; c++) begin
        add_cmd(mk(CMD_WR_REP, s, $urandom, c, rep_word(), $urandom));
        add_cmd(mk(CMD_WR_MASK, s, $urandom, c, sparse_mask(), $urandom));
        for (int j = 0; j < MAX_SYMMETRIES; j++)
          add_cmd(mk(CMD_WR_ACT, s, j, c, image_word(), $urandom));
      end
    drain();

    // directed: ties with no listed symmetry, all-ones candidates, duplicates
    for (int s = 0; s < MAX_SUBLAT; s++) begin
      add_cmd(mk(CMD_WR_REP, s, 0, 0, 32'hFFFF_FF00, '0));
      add_cmd(mk(CMD_WR_MASK, s, 0, 0, '0, '1));
    end
    add_cmd(mk(CMD_FIND, 0, 0, 0, '0, '0));
    for (int s = 0; s < MAX_SUBLAT; s++)
      add_cmd(mk(CMD_WR_MASK, s, 31, 0, '1, '0));
    add_cmd(mk(CMD_WR_ACT, 0, 0, 0, '1, '0));
    add_cmd(mk(CMD_WR_ACT, 3, 31, 3, '0, '1));
    add_cmd(mk(CMD_FIND, 3, 31, 3, '1, '0));
    add_cmd(mk(CMD_FIND, 0, 0, 0, '0, 32'h0303_0303));
    add_cmd(mk(CMD_APPLY, 0, 0, 0, '0, '0));
    add_cmd(mk(CMD_APPLY, 3, 31, 3, '1, 32'h0303_0303));
    add_cmd(mk(3'd5, 3, 31, 255, '1, '1));
    add_cmd(mk(3'd6, 1, 7, 9, '1, '0));
    add_cmd(mk(3'd7, 2, 16, 128, '0, '1));
    drain();

    for (int p = 0; p < 6; p++) begin
      write_cfg(CFG_SITES, 4'(cfg_sites[p]));
      write_cfg(CFG_SUBLATS, 4'(cfg_sublats[p]));
      snd_idle_pct = snd_pct[p];
      rcv_idle_pct = rcv_pct[p];
      for (int k = 0; k < 115; k++) add_cmd(random_cmd());
      drain();
    end

    if (mismatches == 0) begin
      $display("symmetry_representative_lookup_tb: PASS");
    end else begin
      $display("symmetry_representative_lookup_tb: FAIL");
    end
    $finish;
  end

endmodule
